### sv/fas_pkg.sv
// Shared constants and stage types for the float add/subtract pipeline.
package fas_pkg;
	localparam int FRAC_W = 63;
	localparam int EXP_W  = 16;
	localparam int SUM_W  = 64;
	localparam int LZ_W   = 7;
	localparam int EXT_W  = EXP_W + 2;
	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_SUB = 1'b1;

	// operands after ordering, leading one first
	typedef struct packed {
		logic [FRAC_W-1:0] lf;
		logic [FRAC_W-1:0] sf;
		logic signed [EXP_W-1:0] le;
		logic [EXP_W:0] diff;
		logic ls;
		logic eff_sub;
	} align_t;

	// raw sum with its exponent
	typedef struct packed {
		logic [SUM_W-1:0] wf;
		logic signed [EXP_W-1:0] we;
		logic ls;
	} sum_t;
endpackage

### sv/float_add_sub_normalize.sv
// Top level of the float add/subtract unit with normalization.
// Usage:
//   Drive the operand ports and func (0 add, 1 subtract) and raise start.
//   busy is always low, so an item is taken at every edge with start high.
//   Each item gives one result at the end of the pipeline: done is high for exactly
//   one cycle while result_frac, result_exp, result_sign and exp_overflow
//   hold it. The receiver cannot hold results off.
//   The pipeline has four register stages (ordering, align/add,
//   carry and zero count, shift).
//   Throughput: one item per cycle; every stage advances each cycle and
//   nothing in the pipeline ever stalls.
//   Reset (arst_n low) clears all valid bits; items in flight are dropped.
//   Fraction width is 63 bits with the leading one at bit 62; exponents
//   are 16-bit two's complement and wrap with exp_overflow set.
module float_add_sub_normalize import fas_pkg::*; #(
	parameter int ALIGN_LIMIT = 9
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic func,
	input  logic [FRAC_W-1:0] a_frac,
	input  logic signed [EXP_W-1:0] a_exp,
	input  logic a_sign,
	input  logic [FRAC_W-1:0] b_frac,
	input  logic signed [EXP_W-1:0] b_exp,
	input  logic b_sign,
	output logic done,
	output logic [FRAC_W-1:0] result_frac,
	output logic signed [EXP_W-1:0] result_exp,
	output logic result_sign,
	output logic exp_overflow
);
	logic sum_vld;
	sum_t sum;

	assign busy = 1'b0;

	fas_align #(.ALIGN_LIMIT(ALIGN_LIMIT)) u_align (
		.clk, .arst_n, .in_vld(start), .func, .a_frac, .a_exp, .a_sign,
		.b_frac, .b_exp, .b_sign, .out_vld(sum_vld), .out_sum(sum)
	);

	fas_norm u_norm (
		.clk, .arst_n, .in_vld(sum_vld), .in_sum(sum), .out_vld(done),
		.result_frac, .result_exp, .result_sign, .exp_overflow
	);
endmodule

### sv/fas_align.sv
// Stage 1 and 2: operand ordering, then alignment shift and add/subtract.
module fas_align import fas_pkg::*; #(
	parameter int ALIGN_LIMIT = 9
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  logic func,
	input  logic [FRAC_W-1:0] a_frac,
	input  logic signed [EXP_W-1:0] a_exp,
	input  logic a_sign,
	input  logic [FRAC_W-1:0] b_frac,
	input  logic signed [EXP_W-1:0] b_exp,
	input  logic b_sign,
	output logic out_vld,
	output sum_t out_sum
);
	logic bs_eff, swap;
	align_t al_d, al_s1;
	logic vld_s1;
	logic [SUM_W-1:0] shifted, wf_d;

	// order operands
	always_comb begin
		bs_eff = b_sign ^ (func == FUNC_SUB);
		swap = (a_exp < b_exp) || ((a_exp == b_exp) && (a_frac < b_frac));
		if (swap) begin
			al_d.lf = b_frac; al_d.sf = a_frac; al_d.le = b_exp; al_d.ls = bs_eff;
			al_d.diff = {b_exp[EXP_W-1], b_exp} - {a_exp[EXP_W-1], a_exp};
		end else begin
			al_d.lf = a_frac; al_d.sf = b_frac; al_d.le = a_exp; al_d.ls = a_sign;
			al_d.diff = {a_exp[EXP_W-1], a_exp} - {b_exp[EXP_W-1], b_exp};
		end
		al_d.eff_sub = a_sign ^ bs_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= in_vld;
	end
	always_ff @(posedge clk) begin
		al_s1 <= al_d;
	end

	// align and combine, modulo 2^64
	always_comb begin
		shifted = {1'b0, al_s1.sf} >> al_s1.diff;
		if (al_s1.diff >= (EXP_W+1)'(ALIGN_LIMIT)) wf_d = {1'b0, al_s1.lf};
		else if (al_s1.eff_sub) wf_d = {1'b0, al_s1.lf} - shifted;
		else wf_d = {1'b0, al_s1.lf} + shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else out_vld <= vld_s1;
	end
	always_ff @(posedge clk) begin
		out_sum.wf <= wf_d;
		out_sum.we <= al_s1.le;
		out_sum.ls <= al_s1.ls;
	end
endmodule

### sv/fas_norm.sv
// Stages 3 and 4: carry fix, leading zero count, normalize shift, range check.
module fas_norm import fas_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  sum_t in_sum,
	output logic out_vld,
	output logic [FRAC_W-1:0] result_frac,
	output logic signed [EXP_W-1:0] result_exp,
	output logic result_sign,
	output logic exp_overflow
);
	logic [FRAC_W-1:0] f_d, f_s3;
	logic signed [EXT_W-1:0] e_d, e_s3, e_fin;
	logic [LZ_W-1:0] lz_d, lz_s3;
	logic zero_d, zero_s3, ls_s3, vld_s3;

	// carry into bit 63 shifts right once; count zeros above the leading one
	always_comb begin
		zero_d = (in_sum.wf == '0);
		e_d = EXT_W'(in_sum.we);
		if (in_sum.wf[SUM_W-1]) begin
			f_d = in_sum.wf[SUM_W-1:1];
			e_d = e_d + EXT_W'(1);
		end else begin
			f_d = in_sum.wf[FRAC_W-1:0];
		end
		lz_d = '0;
		for (int i = 0; i < FRAC_W; i++)
			if (f_d[i]) lz_d = LZ_W'(FRAC_W - 1 - i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= in_vld;
	end
	always_ff @(posedge clk) begin
		f_s3 <= f_d; e_s3 <= e_d; lz_s3 <= lz_d;
		zero_s3 <= zero_d; ls_s3 <= in_sum.ls;
	end

	// normalize and wrap the exponent
	always_comb begin
		e_fin = e_s3 - EXT_W'(lz_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else out_vld <= vld_s3;
	end
	always_ff @(posedge clk) begin
		result_sign <= ls_s3;
		if (zero_s3) begin
			result_frac <= '0;
			result_exp <= e_s3[EXP_W-1:0];
			exp_overflow <= 1'b0;
		end else begin
			result_frac <= f_s3 << lz_s3;
			result_exp <= e_fin[EXP_W-1:0];
			exp_overflow <= (e_fin[EXT_W-1:EXP_W-1] != {(EXT_W-EXP_W+1){e_fin[EXP_W-1]}});
		end
	end
endmodule

### sv/fas_checker.sv
// Port-level checker for the float add/subtract unit, bound to the top.
module fas_checker import fas_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [FRAC_W-1:0] result_frac,
	input logic exp_overflow
);
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done) else $error("result missing");
	a_nospur: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4)) else $error("spurious result");
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result_frac != '0) |-> result_frac[FRAC_W-1]) else $error("not normalized");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result_frac == '0) |-> !exp_overflow) else $error("overflow on zero");
endmodule

bind float_add_sub_normalize fas_checker u_fas_checker (
	.clk, .arst_n, .start, .busy, .done, .result_frac, .exp_overflow
);

### test/testbench.sv
// Self-checking testbench for float_add_sub_normalize: directed table, then random items.
`timescale 1ns / 100ps

module testbench import fas_pkg::*; ();

	localparam int ALIGN = 9;
	localparam int WATCH_LIMIT = 2000;
	localparam logic [FRAC_W-1:0] ONE = 63'h4000_0000_0000_0000;
	localparam logic [FRAC_W-1:0] ALL = 63'h7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic func;
		logic [FRAC_W-1:0] af;
		logic signed [EXP_W-1:0] ae;
		logic as;
		logic [FRAC_W-1:0] bf;
		logic signed [EXP_W-1:0] be;
		logic bs;
	} operands_t;

	typedef struct {
		logic [FRAC_W-1:0] frac;
		logic signed [EXP_W-1:0] expo;
		logic sign;
		logic ovf;
	} sum_res_t;

	typedef struct {
		operands_t op;
		bit fixed;
		sum_res_t want;
	} row_t;

	logic clk, arst_n, start, busy, func, a_sign, b_sign;
	logic [FRAC_W-1:0] a_frac, b_frac, result_frac;
	logic signed [EXP_W-1:0] a_exp, b_exp, result_exp;
	logic done, result_sign, exp_overflow;

	sum_res_t sums_due[$];
	bit cur_fixed;
	sum_res_t cur_want;
	int errors;
	int quiet;
	int idle_pct;

	float_add_sub_normalize #(.ALIGN_LIMIT(ALIGN)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.a_frac(a_frac), .a_exp(a_exp), .a_sign(a_sign),
		.b_frac(b_frac), .b_exp(b_exp), .b_sign(b_sign),
		.done(done), .result_frac(result_frac), .result_exp(result_exp),
		.result_sign(result_sign), .exp_overflow(exp_overflow)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// expected sum: order, align, add/sub, normalize
	function automatic sum_res_t float_sum(operands_t x);
		sum_res_t r;
		logic [FRAC_W-1:0] lf, sf;
		logic ls, ss, bsign;
		int le, se, diff, we;
		logic [SUM_W-1:0] wf;
		bsign = x.bs ^ x.func;
		if (int'(x.ae) < int'(x.be) || (x.ae == x.be && x.af < x.bf)) begin
			lf = x.bf; le = int'(x.be); ls = bsign;
			sf = x.af; se = int'(x.ae); ss = x.as;
		end else begin
			lf = x.af; le = int'(x.ae); ls = x.as;
			sf = x.bf; se = int'(x.be); ss = bsign;
		end
		diff = le - se;
		we = le;
		if (diff < ALIGN)
			wf = (ls == ss) ? {1'b0, lf} + ({1'b0, sf} >> diff)
				: {1'b0, lf} - ({1'b0, sf} >> diff);
		else
			wf = {1'b0, lf};
		r.ovf = 1'b0;
		if (wf != '0) begin
			if (wf[63]) begin
				wf = wf >> 1;
				we = we + 1;
			end
			while (!wf[62]) begin
				wf = wf << 1;
				we = we - 1;
			end
			r.ovf = (we < -32768 || we > 32767);
		end
		r.frac = wf[FRAC_W-1:0];
		r.expo = we[EXP_W-1:0];
		r.sign = ls;
		return r;
	endfunction

	task automatic report(string what, logic [FRAC_W-1:0] got, logic [FRAC_W-1:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// input side: predict on acceptance; output side: compare
	always @(posedge clk) begin
		operands_t o;
		sum_res_t w;
		if (arst_n && start && !busy) begin
			o = '{func, a_frac, a_exp, a_sign, b_frac, b_exp, b_sign};
			sums_due.push_back(cur_fixed ? cur_want : float_sum(o));
		end
		if (arst_n && done) begin
			if (sums_due.size() == 0) begin
				report("unexpected result", result_frac, '0);
			end else begin
				w = sums_due.pop_front();
				if (result_frac !== w.frac) report("result_frac", result_frac, w.frac);
				if (result_exp !== w.expo)
					report("result_exp", 63'(result_exp), 63'(w.expo));
				if (result_sign !== w.sign)
					report("result_sign", 63'(result_sign), 63'(w.sign));
				if (exp_overflow !== w.ovf)
					report("exp_overflow", 63'(exp_overflow), 63'(w.ovf));
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCH_LIMIT) begin
			$display("float_add_sub_normalize test failed");
			$finish;
		end
	end

	// send one item, with random sender gaps
	task automatic send(operands_t o, bit fixed, sum_res_t want);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		{func, a_frac, a_exp, a_sign} <= {o.func, o.af, o.ae, o.as};
		{b_frac, b_exp, b_sign} <= {o.bf, o.be, o.bs};
		cur_fixed <= fixed;
		cur_want <= want;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic [FRAC_W-1:0] rand_frac();
		logic [FRAC_W-1:0] f;
		f = FRAC_W'({$urandom, $urandom});
		case ($urandom_range(9))
			0: f = '0;
			1: f = f >> $urandom_range(62);
			2: f = ALL;
			3, 4: ;
			default: f[62] = 1'b1;
		endcase
		return f;
	endfunction

	function automatic operands_t rand_ops();
		operands_t o;
		o.func = 1'($urandom_range(1));
		o.as = 1'($urandom_range(1));
		o.bs = 1'($urandom_range(1));
		o.af = rand_frac();
		o.bf = ($urandom_range(7) == 0) ? o.af : rand_frac();
		case ($urandom_range(9))
			0: o.ae = EXP_W'(32767 - int'($urandom_range(3)));
			1: o.ae = EXP_W'(-32768 + int'($urandom_range(3)));
			default: o.ae = EXP_W'($urandom);
		endcase
		if ($urandom_range(5) == 0)
			o.be = EXP_W'($urandom);
		else
			o.be = EXP_W'(int'(o.ae) + int'($urandom_range(24)) - 12);
		return o;
	endfunction

	initial begin
		row_t rows[$];
		sum_res_t none;
		int phase_idle[4] = '{0, 64, 30, 0};
		none = '{'0, '0, 1'b0, 1'b0};
		errors = 0;
		quiet = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cur_fixed = 1'b0;
		cur_want = none;
		{func, a_frac, a_exp, a_sign, b_frac, b_exp, b_sign} = '0;

		// directed cases
		rows.push_back('{'{FUNC_ADD, ONE, 0, 0, ONE, 0, 0}, 1, '{ONE, 1, 0, 0}});
		rows.push_back('{'{FUNC_SUB, ONE, 0, 0, ONE, 0, 0}, 1, '{'0, 0, 0, 0}});
		rows.push_back('{'{FUNC_ADD, ONE, 16'sh7FFF, 0, ONE, 16'sh7FFF, 0}, 1,
			'{ONE, -16'sh8000, 0, 1}});
		rows.push_back('{'{FUNC_SUB, 63'h6000_0000_0000_0000, -16'sh8000, 1, ONE,
			-16'sh8000, 1}, 1, '{ONE, 16'sh7FFF, 1, 1}});
		rows.push_back('{'{FUNC_ADD, ONE, 9, 0, ONE, 0, 0}, 1, '{ONE, 9, 0, 0}});
		rows.push_back('{'{FUNC_ADD, ONE, 8, 0, ALL, 0, 0}, 0, none});
		rows.push_back('{'{FUNC_ADD, ALL, 5, 1, ALL, 5, 1}, 0, none});
		rows.push_back('{'{FUNC_ADD, '0, 5, 1, '0, 3, 0}, 1, '{'0, 5, 1, 0}});
		rows.push_back('{'{FUNC_SUB, ONE, -3, 1, ALL, 2, 1}, 0, none});
		rows.push_back('{'{FUNC_ADD, 63'd1, 0, 0, '0, 0, 0}, 1, '{ONE, -62, 0, 0}});
		rows.push_back('{'{FUNC_ADD, 63'd1, 1, 0, ALL, 0, 1}, 0, none});
		rows.push_back('{'{FUNC_ADD, ALL, 7, 0, ALL, 7, 1}, 0, none});
		rows.push_back('{'{FUNC_SUB, ALL, 1, 0, ALL, 0, 0}, 0, none});
		rows.push_back('{'{FUNC_SUB, 63'd1, -16'sh8000, 0, ONE, 16'sh7FFF, 0}, 0, none});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send(rows[i].op, rows[i].fixed, rows[i].want);

		// random phases with different sender idling
		foreach (phase_idle[p]) begin
			idle_pct = phase_idle[p];
			repeat (250) send(rand_ops(), 0, none);
			// hold off until the pipeline has drained; the last item is
			// queued once this edge has passed
			start <= 1'b0;
			@(posedge clk);
			while (sums_due.size() != 0) @(posedge clk);
		end

		repeat (10) @(posedge clk);
		if (errors == 0 && sums_due.size() == 0)
			$display("float_add_sub_normalize test passed");
		else
			$display("float_add_sub_normalize test failed");
		$finish;
	end
endmodule

### filelist.f
sv/fas_pkg.sv
sv/fas_align.sv
sv/fas_norm.sv
sv/float_add_sub_normalize.sv
sv/fas_checker.sv
test/testbench.sv
